/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_SCREEN_ROWS = 25;
    localparam int DEF_SCREEN_COLS = 80;

    localparam int ROW_FIELD_W  = 5;
    localparam int COL_FIELD_W  = 7;
    localparam int CHAR_W       = 8;
    localparam int CELL_W       = 16;
    localparam int OP_W         = 3;
    localparam int S_DATA_W     = 40;
    localparam int M_DATA_W     = 32;

    localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, CHAR_SPACE};

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR    = 3'd0,
        OP_CLEAR       = 3'd1,
        OP_MOVE_CURSOR = 3'd2,
        OP_WRITE_CELL  = 3'd3,
        OP_READ_CELL   = 3'd4
    } tcw_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_HOLD
    } tcw_state_t;

    function automatic logic [M_DATA_W-1:0] pack_result(
        input logic [ROW_FIELD_W-1:0] row,
        input logic [COL_FIELD_W-1:0] col,
        input logic [CELL_W-1:0]      word
    );
        return {4'b0000, word, col, row};
    endfunction

endpackage

/* src/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: screen store in one RAM, cursor, scroll and clear.
// Flow: put_char, cursor moves and write_cell finish in ST_IDLE; read_cell
//   finishes in ST_READ from the registered RAM read; a put_char that scrolls
//   runs ST_COPY then ST_BLANK; clear runs ST_CLEAR over every cell.
// Requests: one at a time; a result the output cannot take waits in ST_HOLD.
// Reset: synchronous, active low; a fill pass in ST_INIT writes the
//   blank cell to the store, with no request taken until it ends.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
    parameter int SCREEN_COLS = DEF_SCREEN_COLS
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config: text_attribute
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CHAR_W-1:0]   cfg_data,
    // request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // char_code, target_row, target_col, cell_word
    input  logic [OP_W-1:0]     s_tuser,   // opcode
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // cursor_row, cursor_col, read_word
);

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int COL_W      = $clog2(SCREEN_COLS);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS - 1);
    localparam logic [ADDR_W-1:0] BLANK_BASE = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(SCREEN_COLS - 1);

    tcw_state_t state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [CHAR_W-1:0]   attr_reg, attr_next;
    logic [CELL_W-1:0]   rd_reg, rd_next;
    logic                inside_reg, inside_next;
    logic                cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]   cp_addr_reg, cp_addr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    tcw_op_t                 op;
    logic [CHAR_W-1:0]       in_char;
    logic [ROW_FIELD_W-1:0]  in_row;
    logic [COL_FIELD_W-1:0]  in_col;
    logic [CELL_W-1:0]       in_word;
    logic                    in_inside;
    logic [ADDR_W-1:0]       in_addr;
    logic [ADDR_W-1:0]       cur_addr;
    logic [CELL_W-1:0]       blank_cell;
    logic                    accept;
    logic                    m_free;
    logic                    finish;
    logic [CELL_W-1:0]       fin_rd;

    assign op        = tcw_op_t'(s_tuser);
    assign in_char   = s_tdata[7:0];
    assign in_row    = s_tdata[12:8];
    assign in_col    = s_tdata[19:13];
    assign in_word   = s_tdata[35:20];
    assign in_inside = (32'(in_row) < SCREEN_ROWS) && (32'(in_col) < SCREEN_COLS);
    assign in_addr   = ADDR_W'(32'(in_row) * SCREEN_COLS + 32'(in_col));
    assign cur_addr  = ADDR_W'(32'(cur_row_reg) * SCREEN_COLS + 32'(cur_col_reg));
    assign blank_cell = {attr_reg, CHAR_SPACE};

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_free    = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    tcw_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELL_COUNT)
    ) u_screen (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            attr_reg     <= RESET_ATTR;
            cp_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            attr_reg     <= attr_next;
            cp_valid_reg <= cp_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg      <= rd_next;
        inside_reg  <= inside_next;
        cp_addr_reg <= cp_addr_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        attr_next     = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;
        rd_next       = rd_reg;
        inside_next   = inside_reg;
        cp_valid_next = cp_valid_reg;
        cp_addr_next  = cp_addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = blank_cell;
        ram_raddr     = '0;
        finish        = 1'b0;
        fin_rd        = '0;

        case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
                if (cnt_reg == CELL_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_PUT_CHAR: begin
                            if (in_char != CHAR_NEWLINE) begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_addr;
                                ram_wdata = {attr_reg, in_char};
                            end
                            if (in_char != CHAR_NEWLINE && cur_col_reg != COL_LAST) begin
                                cur_col_next = cur_col_reg + 1'b1;
                                finish       = 1'b1;
                            end else begin
                                cur_col_next = '0;
                                if (cur_row_reg == ROW_LAST) begin
                                    cnt_next      = '0;
                                    cp_valid_next = 1'b0;
                                    state_next    = ST_COPY;
                                end else begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    finish       = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                            cnt_next     = '0;
                            state_next   = ST_CLEAR;
                        end
                        OP_MOVE_CURSOR: begin
                            cur_row_next = (32'(in_row) < SCREEN_ROWS) ? ROW_W'(in_row)
                                                                        : ROW_LAST;
                            cur_col_next = (32'(in_col) < SCREEN_COLS) ? COL_W'(in_col)
                                                                        : COL_LAST;
                            finish       = 1'b1;
                        end
                        OP_WRITE_CELL: begin
                            ram_we    = in_inside;
                            ram_waddr = in_addr;
                            ram_wdata = in_word;
                            finish    = 1'b1;
                        end
                        OP_READ_CELL: begin
                            ram_raddr   = in_inside ? in_addr : '0;
                            inside_next = in_inside;
                            state_next  = ST_READ;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                finish = 1'b1;
                fin_rd = inside_reg ? ram_rdata : '0;
            end
            ST_COPY: begin
                ram_raddr     = cnt_reg + ROW_STRIDE;
                ram_we        = cp_valid_reg;
                ram_waddr     = cp_addr_reg;
                ram_wdata     = ram_rdata;
                cp_valid_next = 1'b1;
                cp_addr_next  = cnt_reg;
                if (cnt_reg == COPY_LAST) begin
                    cnt_next   = BLANK_BASE;
                    state_next = ST_BLANK;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BLANK: begin
                ram_we = 1'b1;
                if (cp_valid_reg) begin
                    ram_waddr     = cp_addr_reg;
                    ram_wdata     = ram_rdata;
                    cp_valid_next = 1'b0;
                end else if (cnt_reg == CELL_LAST) begin
                    finish = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (cnt_reg == CELL_LAST) begin
                    finish = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HOLD: begin
                finish = 1'b1;
                fin_rd = rd_reg;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            if (m_free) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = pack_result(ROW_FIELD_W'(cur_row_next),
                                            COL_FIELD_W'(cur_col_next), fin_rd);
                state_next    = ST_IDLE;
            end else begin
                rd_next    = fin_rd;
                state_next = ST_HOLD;
            end
        end
    end

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_row_reg) < SCREEN_ROWS) && (32'(cur_col_reg) < SCREEN_COLS))
        else $error("cursor left the screen");

    a_copy_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && ram_we) |-> (ram_waddr < ram_raddr))
        else $error("scroll write overtook its read");

    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> m_tvalid_reg)
        else $error("result held with output register empty");

endmodule
